### rtl/ltxc_pkg.sv
// ltxc_pkg: shared types and constants for the keystream XOR cipher.
// Beat structs, generator constants and lane geometry; no dependencies.

package ltxc_pkg;

  localparam int SECTION_BYTES_DEF = 64;
  localparam int SECTION_COUNT_DEF = 256;

  localparam logic [31:0] LCG_SEED = 32'hDEAD_BEEF;
  localparam logic [17:0] LCG_MUL  = 18'd214013;
  localparam logic [31:0] LCG_ADD  = 32'd2531011;

  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int KEY_REACH = 8 * LANES;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  key_select;
    logic        first_unit;
    logic [2:0]  word_index;
    logic [63:0] data_word;
    logic        full_word;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        last_out;
  } out_beat_t;

  typedef logic [7:0]             key_byte_t;
  typedef key_byte_t [LANES-1:0]  key_word_t;

endpackage

### rtl/lcg_table_xor_stream_cipher.sv
// lcg_table_xor_stream_cipher: top level, four-stage cipher pipeline.
// Instantiates ltxc_fill and ltxc_keystore; types from ltxc_pkg.
//
//   channel | ports                         | beat
//   in      | in_valid, in_ready, in_beat   | in_beat_t, one data word
//   out     | out_valid, out_ready, out_beat| out_beat_t, one result word
//
// One beat per cycle once the fill is done and while out_ready is high; the stages
// are section lookup, base address, bank read, mix and output register.
// After reset the fill sequencer writes one store byte per cycle:
// ((SECTION_BYTES*SECTION_COUNT + 64 + 7) / 8) * 8 bytes, 16448 at defaults,
// with in_ready low throughout. A stall on out_ready holds every full stage.

module lcg_table_xor_stream_cipher import ltxc_pkg::*; #(
  parameter int SECTION_BYTES = SECTION_BYTES_DEF,
  parameter int SECTION_COUNT = SECTION_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  localparam int STORE_BYTES = SECTION_BYTES * SECTION_COUNT;
  localparam int EXT_BYTES   = ((STORE_BYTES + KEY_REACH + LANES - 1) / LANES) * LANES;
  localparam int POS_W       = $clog2(EXT_BYTES);
  localparam int ROW_W       = POS_W - LANE_W;

  typedef logic [7:0] sect_lut_t [256];

  function automatic sect_lut_t build_sect_lut();
    sect_lut_t lut;
    for (int k = 0; k < 256; k++) begin
      lut[k] = 8'(k % SECTION_COUNT);
    end
    return lut;
  endfunction

  localparam sect_lut_t SECT_LUT = build_sect_lut();

  logic                         wr_en;
  logic [POS_W-1:0]             wr_addr;
  logic [7:0]                   wr_byte;
  logic                         fill_done;
  logic [LANES-1:0][ROW_W-1:0]  rd_row;
  key_word_t                    rd_bank;
  logic                         rd_en;

  logic a_rdy, b_rdy, c_rdy, d_rdy;

  logic             a_v_r;
  in_beat_t         a_beat_r;
  logic [7:0]       a_sect_r;

  logic             b_v_r;
  in_beat_t         b_beat_r;
  logic [POS_W-1:0] b_base_r;
  logic [POS_W-1:0] base_nxt;

  logic             c_v_r;
  in_beat_t         c_beat_r;
  logic [LANE_W-1:0] c_rot_r;

  logic             d_v_r;
  out_beat_t        d_beat_r;
  out_beat_t        d_beat_nxt;

  logic             header;
  logic [63:0]      key_mix;
  logic [63:0]      res_word;

  ltxc_fill #(
    .STORE_BYTES (STORE_BYTES),
    .EXT_BYTES   (EXT_BYTES)
  ) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_byte   (wr_byte),
    .fill_done (fill_done)
  );

  ltxc_keystore #(
    .EXT_BYTES (EXT_BYTES)
  ) u_keystore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_byte (wr_byte),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_bank (rd_bank)
  );

  assign d_rdy    = !d_v_r || out_ready;
  assign c_rdy    = !c_v_r || d_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = fill_done && a_rdy;
  assign rd_en    = c_rdy && b_v_r;

  assign base_nxt = POS_W'(32'(a_sect_r) * SECTION_BYTES)
                  + POS_W'({a_beat_r.word_index, 3'b000});

  // bank j serves output byte (j - base) mod 8
  always_comb begin
    logic [LANE_W-1:0] lane_off;
    logic [POS_W-1:0]  addr;
    for (int j = 0; j < LANES; j++) begin
      lane_off  = LANE_W'(j) - b_base_r[LANE_W-1:0];
      addr      = b_base_r + POS_W'(lane_off);
      rd_row[j] = addr[POS_W-1:LANE_W];
    end
  end

  always_comb begin
    logic [LANE_W-1:0] sel;
    header = (c_beat_r.opcode == OP_ENCRYPT) && c_beat_r.first_unit
          && (c_beat_r.word_index == 3'd0);
    for (int b = 0; b < LANES; b++) begin
      sel                = c_rot_r + LANE_W'(b);
      key_mix[8*b +: 8]  = rd_bank[sel];
    end
    if (header) begin
      key_mix[31:0] = '0;
    end
    res_word = c_beat_r.data_word;
    if (header) begin
      res_word[31:24] = c_beat_r.key_select;
    end
    if (c_beat_r.full_word) begin
      res_word = res_word ^ key_mix;
    end
    d_beat_nxt.result_word = res_word;
    d_beat_nxt.last_out    = c_beat_r.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid && fill_done;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (c_rdy) begin
        c_v_r <= b_v_r;
      end
      if (d_rdy) begin
        d_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_beat_r <= in_beat;
      a_sect_r <= SECT_LUT[in_beat.key_select];
    end
    if (b_rdy && a_v_r) begin
      b_beat_r <= a_beat_r;
      b_base_r <= base_nxt;
    end
    if (rd_en) begin
      c_beat_r <= b_beat_r;
      c_rot_r  <= b_base_r[LANE_W-1:0];
    end
    if (d_rdy && c_v_r) begin
      d_beat_r <= d_beat_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_beat  = d_beat_r;

endmodule

### rtl/ltxc_fill.sv
// ltxc_fill: generator sequencer that writes the keystream store after reset.
// One byte per cycle; restarts from the seed each store period. Uses ltxc_pkg.

module ltxc_fill import ltxc_pkg::*; #(
  parameter int STORE_BYTES = SECTION_BYTES_DEF * SECTION_COUNT_DEF,
  parameter int EXT_BYTES   = SECTION_BYTES_DEF * SECTION_COUNT_DEF + KEY_REACH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         wr_en,
  output logic [$clog2(EXT_BYTES)-1:0] wr_addr,
  output logic [7:0]                   wr_byte,
  output logic                         fill_done
);

  localparam int POS_W = $clog2(EXT_BYTES);
  localparam int PER_W = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    FILL_RUN  = 2'b01,
    FILL_DONE = 2'b10
  } fill_state_t;

  fill_state_t      state_r, state_nxt;
  logic [31:0]      gen_r, gen_nxt;
  logic [31:0]      gen_prod;
  logic [31:0]      gen_step;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic             per_wrap;
  logic             pos_last;

  assign gen_prod = gen_r * 32'(LCG_MUL);
  assign gen_step = gen_prod + LCG_ADD;
  assign per_wrap = (per_r == PER_W'(STORE_BYTES - 1));
  assign pos_last = (pos_r == POS_W'(EXT_BYTES - 1));

  assign wr_addr   = pos_r;
  assign wr_byte   = gen_step[23:16];
  assign fill_done = (state_r == FILL_DONE);

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    pos_nxt   = pos_r;
    per_nxt   = per_r;
    wr_en     = 1'b0;
    unique case (state_r)
      FILL_RUN: begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + 1'b1;
        per_nxt = per_wrap ? '0 : per_r + 1'b1;
        gen_nxt = per_wrap ? LCG_SEED : gen_step;
        if (pos_last) begin
          state_nxt = FILL_DONE;
        end
      end
      FILL_DONE: begin
        state_nxt = FILL_DONE;
      end
      default: begin
        state_nxt = FILL_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL_RUN;
      gen_r   <= LCG_SEED;
      pos_r   <= '0;
      per_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      pos_r   <= pos_nxt;
      per_r   <= per_nxt;
    end
  end

endmodule

### rtl/ltxc_keystore.sv
// ltxc_keystore: keystream store as eight byte-wide banks, one per lane.
// Byte write from the fill sequencer, registered eight-row read. Uses ltxc_pkg.

module ltxc_keystore import ltxc_pkg::*; #(
  parameter int EXT_BYTES = SECTION_BYTES_DEF * SECTION_COUNT_DEF + KEY_REACH
) (
  input  logic                                            clk,
  input  logic                                            wr_en,
  input  logic [$clog2(EXT_BYTES)-1:0]                    wr_addr,
  input  logic [7:0]                                      wr_byte,
  input  logic                                            rd_en,
  input  logic [LANES-1:0][$clog2(EXT_BYTES)-LANE_W-1:0]  rd_row,
  output key_word_t                                       rd_bank
);

  localparam int POS_W = $clog2(EXT_BYTES);
  localparam int ROWS  = EXT_BYTES / LANES;

  for (genvar j = 0; j < LANES; j++) begin : g_bank
    logic [7:0] store_r [ROWS];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_addr[LANE_W-1:0] == LANE_W'(j))) begin
        store_r[wr_addr[POS_W-1:LANE_W]] <= wr_byte;
      end
      if (rd_en) begin
        rd_r <= store_r[rd_row[j]];
      end
    end

    assign rd_bank[j] = rd_r;
  end

endmodule

### rtl/ltxc_chk.sv
// ltxc_chk: port-level checks for lcg_table_xor_stream_cipher, bound below.
// Watches reset, stall hold and pipeline latency. Uses ltxc_pkg.

module ltxc_chk import ltxc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  a_rst_no_accept: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high straight after reset");

  a_rst_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat dropped or changed under stall");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted beat missing at output after four cycles");

endmodule

bind lcg_table_xor_stream_cipher ltxc_chk u_ltxc_chk (.*);
